// File: src/assert_macros.svh
// shared assertion macros, empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/sbc_pkg.sv
`default_nettype none

package sbc_pkg;

    // input item: one big-endian message word
    typedef struct packed {
        logic [31:0] message_word;
        logic        start_of_message;
    } in_item_t;

    // result item: one chaining word
    typedef struct packed {
        logic [31:0] hash_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // five 32-bit chaining words, H0 at index 0
    typedef logic [4:0][31:0] chain_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ENG_LOAD,
        ENG_ROUND,
        ENG_FINAL
    } eng_state_t;

    // input queue geometry
    localparam int IN_Q_DEPTH = 4;
    localparam int IN_Q_AW    = $clog2(IN_Q_DEPTH);

    // standard initial chaining value
    localparam chain_t SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // round constants per group of twenty rounds
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // round counter landmarks
    localparam logic [6:0] PHASE1_START = 7'd20;
    localparam logic [6:0] PHASE2_START = 7'd40;
    localparam logic [6:0] PHASE3_START = 7'd60;
    localparam logic [6:0] LAST_ROUND   = 7'd79;

    // word count and output index landmarks
    localparam logic [3:0] LAST_WORD_COUNT = 4'd15;
    localparam logic [2:0] LAST_HASH_INDEX = 3'd4;

endpackage

`default_nettype wire

// File: src/sbc_in_queue.sv
`default_nettype none

module sbc_in_queue
    import sbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t push_item,
    output logic          full,
    input  wire logic     pop,
    output in_item_t      pop_item,
    output logic          empty
);

    in_item_t                 mem [IN_Q_DEPTH];
    logic [IN_Q_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [IN_Q_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [IN_Q_AW:0]         count_reg, count_next;
    logic                     do_push, do_pop;

    // handshake qualification
    assign full     = (count_reg == (IN_Q_AW+1)'(IN_Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/sbc_engine.sv
`default_nettype none
`include "assert_macros.svh"

module sbc_engine
    import sbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  wire in_item_t q_item,
    output logic          q_pop,
    input  wire logic     ob_busy,
    output logic          ob_load,
    output chain_t        ob_words
);

    eng_state_t  state_reg, state_next;
    logic [3:0]  count_reg, count_next;
    logic [6:0]  round_reg, round_next;
    chain_t      cv_reg, cv_next;
    logic [31:0] sched_reg [16];
    logic [31:0] sched_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [3:0]  base_count;
    logic [31:0] f_val, k_val, w_mix, tmp;

    // round function and constant by group of twenty rounds
    always_comb
    begin
        priority if (round_reg < PHASE1_START)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (round_reg < PHASE2_START)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (round_reg < PHASE3_START)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    // schedule recurrence and round sum
    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign tmp   = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];

    // final addition into the chaining value
    always_comb
    begin
        ob_words[0] = cv_reg[0] + a_reg;
        ob_words[1] = cv_reg[1] + b_reg;
        ob_words[2] = cv_reg[2] + c_reg;
        ob_words[3] = cv_reg[3] + d_reg;
        ob_words[4] = cv_reg[4] + e_reg;
    end

    assign base_count = q_item.start_of_message ? 4'd0 : count_reg;

    // sequencer: collect sixteen words, run eighty rounds, add and hand off
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        cv_next    = cv_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        q_pop      = 1'b0;
        ob_load    = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            sched_next[i] = sched_reg[i];
        end
        unique case (state_reg)
            ENG_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_item.start_of_message)
                    begin
                        cv_next = SHA1_IV;
                    end
                    for (int i = 0; i < 15; i++)
                    begin
                        sched_next[i] = sched_reg[i+1];
                    end
                    sched_next[15] = q_item.message_word;
                    count_next     = base_count + 4'd1;
                    if (base_count == LAST_WORD_COUNT)
                    begin
                        state_next = ENG_ROUND;
                        round_next = '0;
                        a_next     = cv_reg[0];
                        b_next     = cv_reg[1];
                        c_next     = cv_reg[2];
                        d_next     = cv_reg[3];
                        e_next     = cv_reg[4];
                    end
                end
            end
            ENG_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    sched_next[i] = sched_reg[i+1];
                end
                sched_next[15] = {w_mix[30:0], w_mix[31]};
                a_next         = tmp;
                b_next         = a_reg;
                c_next         = {b_reg[1:0], b_reg[31:2]};
                d_next         = c_reg;
                e_next         = d_reg;
                round_next     = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ENG_FINAL;
                end
            end
            ENG_FINAL:
            begin
                if (!ob_busy)
                begin
                    ob_load    = 1'b1;
                    cv_next    = ob_words;
                    state_next = ENG_LOAD;
                end
            end
            default:
            begin
                state_next = ENG_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_LOAD;
            count_reg <= '0;
            round_reg <= '0;
            cv_reg    <= SHA1_IV;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            cv_reg    <= cv_next;
        end
    end

    // schedule window and working variables
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            sched_reg[i] <= sched_next[i];
        end
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    // checks
    `ASSERT_IMPLIES(a_round_range, clk, rst_n, state_reg == ENG_ROUND, round_reg <= LAST_ROUND)
    `ASSERT_IMPLIES(a_pop_only_loading, clk, rst_n, q_pop, state_reg == ENG_LOAD)
    `ASSERT_NEXT(a_block_starts_rounds, clk, rst_n, q_pop && base_count == LAST_WORD_COUNT, state_reg == ENG_ROUND && round_reg == 7'd0)
    `ASSERT_NEXT(a_handoff_returns, clk, rst_n, state_reg == ENG_FINAL && !ob_busy, state_reg == ENG_LOAD)
    `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, ob_load, !ob_busy && state_reg == ENG_FINAL)

endmodule

`default_nettype wire

// File: src/sbc_out_buffer.sv
`default_nettype none

module sbc_out_buffer
    import sbc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   load,
    input  wire chain_t load_words,
    output logic        busy,
    input  wire logic   pop,
    output logic        empty,
    output out_item_t   item
);

    chain_t     words_reg;
    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;

    // current result item
    assign empty           = !valid_reg;
    assign busy            = valid_reg;
    assign item.hash_word  = words_reg[idx_reg];
    assign item.word_index = idx_reg;
    assign item.last_word  = (idx_reg == LAST_HASH_INDEX);

    // walk through H0..H4
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (pop && valid_reg)
        begin
            if (idx_reg == LAST_HASH_INDEX)
            begin
                idx_next   = '0;
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // result words
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            words_reg <= load_words;
        end
    end

endmodule

`default_nettype wire

// File: src/sha1_block_compress.sv
`default_nettype none

// SHA-1 compression of 512-bit blocks fed as sixteen big-endian 32-bit words;
// start_of_message on a word reloads the standard initial chaining value and
// makes that word the first of a new block, otherwise the chaining value
// carries over for multi-block messages. Padding is up to the caller. After
// each sixteenth word five result items come out, H0 to H4, the last flagged.
// Words are taken at one per cycle from a four-entry input queue while the
// block is being collected and the queue is not empty; the single round unit
// then runs 80 rounds at one per cycle, and the final add is handed to the
// result buffer once that buffer is free. Words of the next block queue up
// during the rounds, and results wait in their own buffer.
module sha1_block_compress
    import sbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire in_item_t  message,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output out_item_t      result
);

    in_item_t q_item;
    logic     q_empty;
    logic     q_pop;
    logic     ob_busy;
    logic     ob_load;
    chain_t   ob_words;

    // front: input queue
    sbc_in_queue u_in_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (message),
        .full      (full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    // back: block collection and round engine
    sbc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .ob_busy  (ob_busy),
        .ob_load  (ob_load),
        .ob_words (ob_words)
    );

    // result buffer
    sbc_out_buffer u_out_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ob_load),
        .load_words (ob_words),
        .busy       (ob_busy),
        .pop        (pop),
        .empty      (empty),
        .item       (result)
    );

endmodule

`default_nettype wire
